// File: rtl/core/csl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csl_pkg - shared types and constants for the clock synthesizer loader
// Frame layout, request modes, fixed register addresses and the beat record
// that the serializer hands to the output register.
// ----------------------------------------------------------------------------
package csl_pkg;

    // Frame and preamble sizes
    localparam int FRAME_BITS    = 24;
    localparam int UNLOCK_PULSES = 5;

    // Native word layout: 3-bit address above 21 data bits
    localparam int DATA_BITS = 21;
    localparam int ADDR_BITS = 3;
    localparam int WORD_BITS = DATA_BITS + ADDR_BITS;

    // Fixed register addresses for the control and divider words
    localparam logic [ADDR_BITS-1:0] CTRL_REG_ADDR = 3'd6;
    localparam logic [ADDR_BITS-1:0] DIV_REG_ADDR  = 3'd5;

    typedef logic [FRAME_BITS-1:0] frame_t;

    typedef enum logic [1:0] {
        MODE_RAW  = 2'd0,
        MODE_VCO  = 2'd1,
        MODE_CTRL = 2'd2,
        MODE_DIV  = 2'd3
    } mode_t;

    // One output beat
    typedef struct packed {
        logic       is_pulse;
        logic       data_at_fall;
        logic       data_at_rise;
        logic [1:0] idle_pins;
        logic       last;
    } beat_t;

    // Form the frame sent on the wire: address above data, sized to FRAME_BITS
    function automatic frame_t build_frame(
        input mode_t                mode,
        input logic [ADDR_BITS-1:0] reg_address,
        input logic [DATA_BITS-1:0] raw_word,
        input logic [6:0]           q_field,
        input logic [2:0]           m_field,
        input logic [6:0]           p_field,
        input logic [3:0]           index_field,
        input logic [5:0]           control_bits,
        input logic [2:0]           divider_bits
    );
        logic [ADDR_BITS-1:0] addr;
        logic [DATA_BITS-1:0] data;
        logic [63:0]          wide;
        unique case (mode)
            MODE_RAW: begin
                addr = reg_address;
                data = raw_word;
            end
            MODE_VCO: begin
                addr = reg_address;
                data = {index_field, p_field, m_field, q_field};
            end
            MODE_CTRL: begin
                addr = CTRL_REG_ADDR;
                data = {control_bits, 15'd0};
            end
            default: begin
                addr = DIV_REG_ADDR;
                data = {divider_bits, 18'd0};
            end
        endcase
        wide = {40'd0, addr, data};
        return wide[FRAME_BITS-1:0];
    endfunction

endpackage

// File: rtl/core/csl_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csl_front - request intake
// Decodes the request mode, packs the frame word and pushes it into the queue.
// ----------------------------------------------------------------------------
module csl_front (
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_mode,
    input  logic [2:0]            s_reg_address,
    input  logic [20:0]           s_raw_word,
    input  logic [6:0]            s_q_field,
    input  logic [2:0]            s_m_field,
    input  logic [6:0]            s_p_field,
    input  logic [3:0]            s_index_field,
    input  logic [5:0]            s_control_bits,
    input  logic [2:0]            s_divider_bits,
    output logic                  push_valid,
    input  logic                  push_ready,
    output csl_pkg::frame_t       push_frame
);

    // Handshake passes straight to the queue
    assign push_valid = s_valid;
    assign s_ready    = push_ready;

    // Frame formation per mode
    always_comb begin
        push_frame = csl_pkg::build_frame(csl_pkg::mode_t'(s_mode), s_reg_address,
                                          s_raw_word, s_q_field, s_m_field,
                                          s_p_field, s_index_field,
                                          s_control_bits, s_divider_bits);
    end

endmodule

// File: rtl/core/csl_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csl_queue - two-entry frame queue
// Decouples request intake from the serializer so each side stalls alone.
// ----------------------------------------------------------------------------
module csl_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  csl_pkg::frame_t push_frame,
    output logic            pop_valid,
    input  logic            pop_ready,
    output csl_pkg::frame_t pop_frame
);

    csl_pkg::frame_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg,  count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_frame  = slot_reg[rd_ptr_reg];

    assign do_push = push_valid && push_ready;
    assign do_pop  = pop_valid && pop_ready;

    // Pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_frame;
        end
    end

endmodule

// File: rtl/core/csl_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csl_back - pulse serializer
// Walks one frame through unlock, low, start, frame bits, stop and restore,
// one beat per cycle into a registered output stage, unless m_ready stalls it.
// ----------------------------------------------------------------------------
module csl_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  csl_pkg::frame_t pop_frame,
    input  logic [1:0]      select_levels,
    output logic            m_valid,
    input  logic            m_ready,
    output csl_pkg::beat_t  m_beat
);

    // Pulse index layout: unlock, low, start, frame bits, stop, then restore
    localparam int PULSES = csl_pkg::UNLOCK_PULSES + 2 + csl_pkg::FRAME_BITS + 1;
    localparam int STEP_W = $clog2(PULSES + 1);
    localparam logic [STEP_W-1:0] UNLOCK_END = STEP_W'(csl_pkg::UNLOCK_PULSES);
    localparam logic [STEP_W-1:0] BITS_START = STEP_W'(csl_pkg::UNLOCK_PULSES + 2);
    localparam logic [STEP_W-1:0] BITS_END   =
        STEP_W'(csl_pkg::UNLOCK_PULSES + 2 + csl_pkg::FRAME_BITS);
    localparam logic [STEP_W-1:0] RESTORE_STEP = STEP_W'(PULSES);

    logic                active_reg, active_next;
    logic [STEP_W-1:0]   step_reg,   step_next;
    csl_pkg::frame_t     shift_reg,  shift_next;
    logic                valid_reg,  valid_next;
    csl_pkg::beat_t      beat_reg,   beat_next;
    csl_pkg::beat_t      cur_beat;
    logic                adv;

    assign adv     = !valid_reg || m_ready;
    assign m_valid = valid_reg;
    assign m_beat  = beat_reg;

    // Beat for the current step
    always_comb begin
        cur_beat = '0;
        cur_beat.is_pulse = 1'b1;
        if (step_reg < UNLOCK_END) begin
            cur_beat.data_at_fall = 1'b1;
            cur_beat.data_at_rise = 1'b1;
        end else if (step_reg < BITS_START) begin
            cur_beat.data_at_fall = 1'b0;
            cur_beat.data_at_rise = 1'b0;
        end else if (step_reg < BITS_END) begin
            cur_beat.data_at_fall = ~shift_reg[0];
            cur_beat.data_at_rise = shift_reg[0];
        end else if (step_reg != RESTORE_STEP) begin
            cur_beat.data_at_fall = 1'b1;
            cur_beat.data_at_rise = 1'b1;
        end else begin
            cur_beat.is_pulse  = 1'b0;
            cur_beat.idle_pins = select_levels;
            cur_beat.last      = 1'b1;
        end
    end

    // Sequencer: next frame is taken on the restore beat to keep runs packed
    always_comb begin
        active_next = active_reg;
        step_next   = step_reg;
        shift_next  = shift_reg;
        valid_next  = valid_reg;
        beat_next   = beat_reg;
        pop_ready   = 1'b0;
        if (adv) begin
            valid_next = 1'b0;
        end
        if (active_reg && adv) begin
            valid_next = 1'b1;
            beat_next  = cur_beat;
            step_next  = step_reg + STEP_W'(1);
            if (step_reg >= BITS_START && step_reg < BITS_END) begin
                shift_next = shift_reg >> 1;
            end
            if (step_reg == RESTORE_STEP) begin
                pop_ready   = 1'b1;
                active_next = pop_valid;
                step_next   = '0;
                shift_next  = pop_frame;
            end
        end else if (!active_reg) begin
            pop_ready = 1'b1;
            if (pop_valid) begin
                active_next = 1'b1;
                step_next   = '0;
                shift_next  = pop_frame;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            step_reg   <= '0;
            valid_reg  <= 1'b0;
        end else begin
            active_reg <= active_next;
            step_reg   <= step_next;
            valid_reg  <= valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        beat_reg  <= beat_next;
    end

endmodule

// File: rtl/core/clock_synth_serial_loader_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clock_synth_serial_loader_core - serial loader for a clock synthesizer
// Turns one register-program request into the beat sequence that drives the
// two-wire clock/data load, ending in a restore of the idle pin levels.
// ----------------------------------------------------------------------------
// Each accepted request yields 33 result beats: five unlock pulses, a low
// pulse, a start pulse, 24 frame bits LSB first, a stop pulse, then one
// restore beat flagged last. The serializer emits one beat per cycle while
// m_ready does not stall it; a two-entry frame queue lets up to two further
// requests be accepted while a run is in progress, and consecutive runs
// follow with no gap. A request accepted from idle is queued, popped into
// the serializer's shift register, and its first beat is registered onto
// m_valid. The idle levels are read from the configuration register when
// the restore beat is formed; cfg_ready is always high.
// ----------------------------------------------------------------------------
module clock_synth_serial_loader_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [2:0]  s_reg_address,
    input  logic [20:0] s_raw_word,
    input  logic [6:0]  s_q_field,
    input  logic [2:0]  s_m_field,
    input  logic [6:0]  s_p_field,
    input  logic [3:0]  s_index_field,
    input  logic [5:0]  s_control_bits,
    input  logic [2:0]  s_divider_bits,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_is_pulse,
    output logic        m_data_at_fall,
    output logic        m_data_at_rise,
    output logic [1:0]  m_idle_pins,
    output logic        m_last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data
);

    logic            push_valid, push_ready;
    csl_pkg::frame_t push_frame;
    logic            pop_valid, pop_ready;
    csl_pkg::frame_t pop_frame;
    csl_pkg::beat_t  beat;
    logic [1:0]      select_levels_reg;

    // Configuration register
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            select_levels_reg <= 2'd0;
        end else if (cfg_valid) begin
            select_levels_reg <= cfg_data;
        end
    end

    csl_front u_front (
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_mode         (s_mode),
        .s_reg_address  (s_reg_address),
        .s_raw_word     (s_raw_word),
        .s_q_field      (s_q_field),
        .s_m_field      (s_m_field),
        .s_p_field      (s_p_field),
        .s_index_field  (s_index_field),
        .s_control_bits (s_control_bits),
        .s_divider_bits (s_divider_bits),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_frame     (push_frame)
    );

    csl_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_frame (push_frame),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_frame  (pop_frame)
    );

    csl_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_frame     (pop_frame),
        .select_levels (select_levels_reg),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_beat        (beat)
    );

    // Output beat fields
    assign m_is_pulse     = beat.is_pulse;
    assign m_data_at_fall = beat.data_at_fall;
    assign m_data_at_rise = beat.data_at_rise;
    assign m_idle_pins    = beat.idle_pins;
    assign m_last         = beat.last;

endmodule
